// ===== sv/per_source_fixed_window_bit_policer_unit_macros.svh =====
// assertion macros shared by the policer modules
// expects clk and rst_n in the scope of each use
`ifndef PER_SOURCE_FIXED_WINDOW_BIT_POLICER_UNIT_MACROS_SVH
`define PER_SOURCE_FIXED_WINDOW_BIT_POLICER_UNIT_MACROS_SVH

// same-cycle implication
`define PSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("policer check failed");

// next-cycle implication
`define PSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("policer check failed");

`endif

// ===== sv/psp_pkg.sv =====
// shared constants and types of the per-source bit policer
// no dependencies
`default_nettype none
package psp_pkg;
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned COUNT_W = 40;
  localparam int unsigned BITS_W  = 19;
  localparam int unsigned ENTRY_W = 64 + COUNT_W;

  localparam logic [15:0] IPV4_TYPE      = 16'h0800;
  localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
  localparam logic [31:0] WINDOW_RESET   = 32'd1000000000;
  localparam logic [31:0] LIMIT_RESET    = 32'd10000000;

  // register index decode
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic             insert;
    logic [IDX_W-1:0] idx;
  } srch_res_t;
endpackage
`default_nettype wire

// ===== sv/psp_search.sv =====
// key table: linear scan over the filled part of the key memory, insert on miss while not full
// depends on psp_pkg and the policer macro header
`default_nettype none
`include "per_source_fixed_window_bit_policer_unit_macros.svh"
module psp_search import psp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] key,
  output srch_res_t        res
);
  logic [31:0]       mem [TABLE_ENTRIES];
  logic              busy_r;
  logic [FILL_W-1:0] addr_r;
  logic [FILL_W-1:0] fill_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic [31:0]       key_r;
  logic [31:0]       rdata_r;
  logic              issue;
  logic              match;
  logic              miss;

  // one read issued per cycle, compared in the next cycle
  always_comb begin
    issue      = busy_r && (addr_r < fill_r);
    match      = busy_r && pend_r && (rdata_r == key_r);
    miss       = busy_r && !issue && !pend_r;
    res.done   = match || miss;
    res.hit    = match;
    res.insert = miss && (fill_r < FILL_W'(TABLE_ENTRIES));
    res.idx    = match ? pend_idx_r : fill_r[IDX_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      fill_r <= '0;
      addr_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      pend_r <= 1'b0;
      addr_r <= '0;
    end else if (busy_r) begin
      if (res.done) begin
        busy_r <= 1'b0;
      end
      if (res.insert) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      pend_r <= issue && !match;
      if (issue) begin
        addr_r <= addr_r + FILL_W'(1);
      end
    end
  end

  // key memory and scan payload
  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    if (res.insert) begin
      mem[fill_r[IDX_W-1:0]] <= key_r;
    end
    rdata_r    <= mem[addr_r[IDX_W-1:0]];
    pend_idx_r <= addr_r[IDX_W-1:0];
  end

  `PSP_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FILL_W'(TABLE_ENTRIES))
  `PSP_ASSERT_NOW(a_hit_filled, res.hit, {1'b0, pend_idx_r} < {1'b0, fill_r})
  `PSP_ASSERT_NEXT(a_insert_grows, res.insert, fill_r == $past(fill_r) + FILL_W'(1))
endmodule
`default_nettype wire

// ===== sv/psp_update.sv =====
// window state memory: read, check window, add bits, write back, verdict; a fresh source's entry is written new
// depends on psp_pkg
`default_nettype none
module psp_update import psp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic              fresh,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [63:0]       now,
  input  wire logic [BITS_W-1:0] bits,
  input  wire logic [31:0]       window,
  input  wire logic [31:0]       limit,
  output logic                   done,
  output logic                   verdict
);
  localparam logic [1:0] U_IDLE  = 2'd0;
  localparam logic [1:0] U_CALC  = 2'd1;
  localparam logic [1:0] U_WRITE = 2'd2;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [1:0]         st_r;
  logic [IDX_W-1:0]   idx_r;
  logic [63:0]        now_r;
  logic [BITS_W-1:0]  bits_r;
  logic [ENTRY_W-1:0] rd_r;
  logic [63:0]        start_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               inwin_r;
  logic               done_r;
  logic               verdict_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [63:0]        age;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat;

  // age and saturating count
  always_comb begin
    rd_addr = (st_r == U_IDLE) ? idx : idx_r;
    age     = now_r - rd_r[ENTRY_W-1:COUNT_W];
    sum     = {1'b0, cnt_r} + (COUNT_W+1)'(bits_r);
    sat     = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (go && fresh) begin
            done_r <= 1'b1;
          end else if (go) begin
            st_r <= U_CALC;
          end
        end
        U_CALC:  st_r <= U_WRITE;
        U_WRITE: begin
          st_r   <= U_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  // state memory and datapath
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (st_r == U_IDLE && go) begin
      idx_r     <= idx;
      now_r     <= now;
      bits_r    <= bits;
      verdict_r <= 1'b0;
      if (fresh) begin
        mem[idx] <= {now, COUNT_W'(bits)};
      end
    end
    if (st_r == U_CALC) begin
      inwin_r <= age < {32'd0, window};
      start_r <= rd_r[ENTRY_W-1:COUNT_W];
      cnt_r   <= rd_r[COUNT_W-1:0];
    end
    if (st_r == U_WRITE) begin
      if (inwin_r) begin
        mem[idx_r] <= {start_r, sat};
        verdict_r  <= sat > COUNT_W'(limit);
      end else begin
        mem[idx_r] <= {now_r, COUNT_W'(bits_r)};
        verdict_r  <= 1'b0;
      end
    end
  end

  assign done    = done_r;
  assign verdict = verdict_r;
endmodule
`default_nettype wire

// ===== sv/per_source_fixed_window_bit_policer_unit.sv =====
// Per-source fixed-window bit policer, top level.
// Input channel in_*: one frame descriptor per transfer (ethertype, length,
// IPv4 source, timestamp). Output channel out_*: one pass/drop verdict per
// frame, in order. Configuration on an APB-style port: window_ns at 0x0,
// limit_bits at 0x4. The user must write them only while the block is idle;
// the block itself does not enforce this. Frames are handled one at a time.
// A short or non-IPv4 frame skips the search and goes to the done state,
// which loads a pass verdict into the output register. Otherwise the key
// memory is scanned one entry a cycle over the filled entries (up to 1024
// sources), a rate set by its single read port; the state memory then
// reads, checks and writes back a known source's entry, or writes a new one
// if the table has room; else the frame passes. Reset clears the fill count,
// so the table starts empty with no clearing pass; configuration is reset too.
// The verdict sits in an output register; while the receiver stalls, the
// block finishes the next frame and then holds it until the register frees.
// depends on psp_pkg, psp_search, psp_update and the macro header
`default_nettype none
`include "per_source_fixed_window_bit_policer_unit_macros.svh"
module per_source_fixed_window_bit_policer_unit import psp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [15:0] in_frame_bytes,
  input  wire logic [31:0] in_source_address,
  input  wire logic [63:0] in_now_ns,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_verdict,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_SEARCH = 2'd1;
  localparam logic [1:0] T_UPDATE = 2'd2;
  localparam logic [1:0] T_DONE   = 2'd3;

  logic [1:0]        st_r;
  logic [31:0]       window_r;
  logic [31:0]       limit_r;
  logic [63:0]       now_r;
  logic [BITS_W-1:0] bits_r;
  logic              res_verdict_r;
  logic              out_valid_r;
  logic              out_verdict_r;
  logic              in_xfer;
  logic              filtered;
  logic              srch_start;
  srch_res_t         srch_res;
  logic              upd_go;
  logic              upd_done;
  logic              upd_verdict;
  logic              out_load;

  // handshakes and frame filter
  always_comb begin
    in_ready   = (st_r == T_IDLE);
    in_xfer    = in_valid && in_ready;
    filtered   = (in_frame_bytes < IPV4_MIN_BYTES) || (in_ether_type != IPV4_TYPE);
    srch_start = in_xfer && !filtered;
    upd_go     = (st_r == T_SEARCH) && srch_res.done && (srch_res.hit || srch_res.insert);
    out_load   = (st_r == T_DONE) && (!out_valid_r || out_ready);
  end

  psp_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .key   (in_source_address),
    .res   (srch_res)
  );

  psp_update u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (upd_go),
    .fresh   (srch_res.insert),
    .idx     (srch_res.idx),
    .now     (now_r),
    .bits    (bits_r),
    .window  (window_r),
    .limit   (limit_r),
    .done    (upd_done),
    .verdict (upd_verdict)
  );

  // frame sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      unique case (st_r)
        T_IDLE: begin
          if (in_xfer) begin
            st_r <= filtered ? T_DONE : T_SEARCH;
          end
        end
        T_SEARCH: begin
          if (srch_res.done) begin
            st_r <= upd_go ? T_UPDATE : T_DONE;
          end
        end
        T_UPDATE: begin
          if (upd_done) begin
            st_r <= T_DONE;
          end
        end
        T_DONE: begin
          if (out_load) begin
            st_r <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  // frame payload and pending verdict
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r         <= in_now_ns;
      bits_r        <= {in_frame_bytes, 3'b000};
      res_verdict_r <= 1'b0;
    end else if (st_r == T_UPDATE && upd_done) begin
      res_verdict_r <= upd_verdict;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict_r <= res_verdict_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_WINDOW: window_r <= cfg_pwdata;
        REG_LIMIT:  limit_r  <= cfg_pwdata;
        default:    window_r <= window_r;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LIMIT) ? limit_r : window_r;
  assign cfg_pready = 1'b1;

  `PSP_ASSERT_NOW(a_srch_in_search, srch_res.done, st_r == T_SEARCH)
  `PSP_ASSERT_NOW(a_upd_in_update, upd_done, st_r == T_UPDATE)
  `PSP_ASSERT_NEXT(a_accept_busy, in_xfer, st_r != T_IDLE)
endmodule
`default_nettype wire
